[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TTD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ttd_pkg.sv]
// Shared types, constants and the CORDIC angle table for the tilt-to-drive block.
package ttd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC_BITS    = 16;
    localparam int XY_W         = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int ANG_W        = FRAC_BITS + 10;
    localparam int MAG_W        = ANG_W - 1;
    localparam int T_W          = ANG_W - FRAC_BITS;
    localparam int NUM_W        = 16;
    localparam int DIV_STEPS    = 8;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_AW    = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = 1;

    localparam logic [7:0] SERVO_MAX  = 8'd180;
    localparam logic [7:0] SPEED_MAX  = 8'd255;
    localparam int         SERVO_GAIN = 90;

    localparam logic [1:0] CFG_DEADBAND  = 2'd0;
    localparam logic [1:0] CFG_MAX_ANGLE = 2'd1;
    localparam logic [1:0] CFG_SPAN      = 2'd2;

    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t ANG_90  = ang_t'(90 * (1 << FRAC_BITS));
    localparam ang_t ANG_180 = ang_t'(180 * (1 << FRAC_BITS));

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [6:0] deadband;
        logic [7:0] max_angle;
        logic [7:0] span;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{deadband: 7'd10, max_angle: 8'd30, span: 8'd75};

    typedef struct packed {
        ang_t servo;
        ang_t motor;
    } ang_pair_t;

    typedef struct packed {
        logic [7:0] servo_position;
        logic [7:0] motor_speed;
        dir_t       motor_direction;
    } cmd_t;

    // atan(2^-i) in degrees, Q16, rounded
    function automatic ang_t atan_tab(input int idx);
        case (idx)
            0:       return ang_t'(2949120);
            1:       return ang_t'(1740967);
            2:       return ang_t'(919879);
            3:       return ang_t'(466945);
            4:       return ang_t'(234379);
            5:       return ang_t'(117304);
            6:       return ang_t'(58666);
            7:       return ang_t'(29335);
            8:       return ang_t'(14668);
            9:       return ang_t'(7334);
            10:      return ang_t'(3667);
            11:      return ang_t'(1833);
            12:      return ang_t'(917);
            13:      return ang_t'(458);
            14:      return ang_t'(229);
            15:      return ang_t'(115);
            16:      return ang_t'(57);
            17:      return ang_t'(29);
            18:      return ang_t'(14);
            19:      return ang_t'(7);
            20:      return ang_t'(4);
            21:      return ang_t'(2);
            22:      return ang_t'(1);
            default: return '0;
        endcase
    endfunction

endpackage

[rtl/ttd_cordic.sv]
// Pipelined vectoring CORDIC: one micro-rotation per stage, angle in Q16 degrees.
module ttd_cordic (
    input  logic          clk,
    input  logic          en,
    input  ttd_pkg::xy_t  x_in,
    input  ttd_pkg::xy_t  y_in,
    output ttd_pkg::ang_t ang_out
);
    import ttd_pkg::*;

    xy_t  x_w [0:CORDIC_STEPS];
    xy_t  y_w [0:CORDIC_STEPS];
    ang_t a_w [0:CORDIC_STEPS];

    assign x_w[0] = x_in;
    assign y_w[0] = y_in;
    assign a_w[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        xy_t  xs;
        xy_t  ys;
        xy_t  x_next;
        xy_t  y_next;
        ang_t a_next;
        xy_t  x_reg;
        xy_t  y_reg;
        ang_t a_reg;

        // arithmetic shift floors toward minus infinity
        assign xs = x_w[k] >>> k;
        assign ys = y_w[k] >>> k;

        always_comb
        begin
            x_next = x_w[k];
            y_next = y_w[k];
            a_next = a_w[k];
            if (y_w[k] > 0)
            begin
                x_next = x_w[k] + ys;
                y_next = y_w[k] - xs;
                a_next = a_w[k] + atan_tab(k);
            end
            else if (y_w[k] < 0)
            begin
                x_next = x_w[k] - ys;
                y_next = y_w[k] + xs;
                a_next = a_w[k] - atan_tab(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
                a_reg <= a_next;
            end
        end

        assign x_w[k+1] = x_reg;
        assign y_w[k+1] = y_reg;
        assign a_w[k+1] = a_reg;
    end

    assign ang_out = a_w[CORDIC_STEPS];

endmodule

[rtl/ttd_front.sv]
// Front end: takes samples, sorts out the exact atan2 cases, runs both CORDIC pipes.
module ttd_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_z,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output ttd_pkg::ang_pair_t                      out_pair
);
    import ttd_pkg::*;

    typedef struct packed {
        logic special;
        ang_t sval;
        ang_t base;
    } side_t;

    typedef struct packed {
        xy_t   x;
        xy_t   y;
        side_t side;
    } prep_t;

    function automatic prep_t prep(input logic signed [SAMPLE_WIDTH-1:0] num,
                                   input logic signed [SAMPLE_WIDTH-1:0] den);
        prep_t p;
        xy_t   den_q;
        xy_t   num_q;
        logic  neg;
        den_q = xy_t'(den) <<< FRAC_BITS;
        num_q = xy_t'(num) <<< FRAC_BITS;
        neg   = den[SAMPLE_WIDTH-1];
        p.x   = neg ? -den_q : den_q;
        p.y   = neg ? -num_q : num_q;
        p.side.special = (num == '0) || (den == '0);
        if (num == '0)
            p.side.sval = neg ? ANG_180 : '0;
        else
            p.side.sval = num[SAMPLE_WIDTH-1] ? -ANG_90 : ANG_90;
        // left half plane: rotate by 180 and add it back at the end
        if (neg)
            p.side.base = num[SAMPLE_WIDTH-1] ? -ANG_180 : ANG_180;
        else
            p.side.base = '0;
        return p;
    endfunction

    logic                  en;
    logic [CORDIC_STEPS:0] v_reg;
    prep_t                 s_prep;
    prep_t                 m_prep;
    xy_t                   s_x_reg;
    xy_t                   s_y_reg;
    xy_t                   m_x_reg;
    xy_t                   m_y_reg;
    side_t                 s_side_reg [0:CORDIC_STEPS];
    side_t                 m_side_reg [0:CORDIC_STEPS];
    ang_t                  s_ang;
    ang_t                  m_ang;

    assign s_prep = prep(accel_y, accel_z);
    assign m_prep = prep(accel_x, accel_z);

    // whole front advances together; it only holds when its last item can't leave
    assign en   = !v_reg[CORDIC_STEPS] || out_ready;
    assign full = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[CORDIC_STEPS-1:0], push};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_x_reg       <= s_prep.x;
            s_y_reg       <= s_prep.y;
            m_x_reg       <= m_prep.x;
            m_y_reg       <= m_prep.y;
            s_side_reg[0] <= s_prep.side;
            m_side_reg[0] <= m_prep.side;
            for (int k = 1; k <= CORDIC_STEPS; k++)
            begin
                s_side_reg[k] <= s_side_reg[k-1];
                m_side_reg[k] <= m_side_reg[k-1];
            end
        end
    end

    ttd_cordic u_servo_cordic (
        .clk     (clk),
        .en      (en),
        .x_in    (s_x_reg),
        .y_in    (s_y_reg),
        .ang_out (s_ang)
    );

    ttd_cordic u_motor_cordic (
        .clk     (clk),
        .en      (en),
        .x_in    (m_x_reg),
        .y_in    (m_y_reg),
        .ang_out (m_ang)
    );

    assign out_valid      = v_reg[CORDIC_STEPS];
    assign out_pair.servo = s_side_reg[CORDIC_STEPS].special ? s_side_reg[CORDIC_STEPS].sval
                          : s_side_reg[CORDIC_STEPS].base + s_ang;
    assign out_pair.motor = m_side_reg[CORDIC_STEPS].special ? m_side_reg[CORDIC_STEPS].sval
                          : m_side_reg[CORDIC_STEPS].base + m_ang;

endmodule

[rtl/ttd_back.sv]
// Back end: angle queue, servo map and speed ramp with two restoring dividers, result queue.
module ttd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  ttd_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  ttd_pkg::ang_pair_t in_pair,
    output logic               empty,
    input  logic               pop,
    output ttd_pkg::cmd_t      cmd
);
    import ttd_pkg::*;

    typedef struct packed {
        logic zero;
        logic sat;
    } sflag_t;

    typedef struct packed {
        logic dead;
        logic full255;
        dir_t dir;
    } mflag_t;

    // ---------------- angle queue ----------------
    ang_pair_t        mq_mem [0:MQ_DEPTH-1];
    logic [MQ_AW-1:0] mq_wr_reg;
    logic [MQ_AW-1:0] mq_rd_reg;
    logic [MQ_AW:0]   mq_cnt_reg;
    logic             mq_push;
    logic             mq_pop;
    logic             b_en;

    assign in_ready = mq_cnt_reg != (MQ_AW+1)'(MQ_DEPTH);
    assign mq_push  = in_valid && in_ready;
    assign mq_pop   = b_en && (mq_cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mq_wr_reg  <= '0;
            mq_rd_reg  <= '0;
            mq_cnt_reg <= '0;
        end
        else
        begin
            if (mq_push)
                mq_wr_reg <= mq_wr_reg + 1'b1;
            if (mq_pop)
                mq_rd_reg <= mq_rd_reg + 1'b1;
            case ({mq_push, mq_pop})
                2'b10:   mq_cnt_reg <= mq_cnt_reg + 1'b1;
                2'b01:   mq_cnt_reg <= mq_cnt_reg - 1'b1;
                default: mq_cnt_reg <= mq_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mq_push)
            mq_mem[mq_wr_reg] <= in_pair;
    end

    // ---------------- valid pipeline ----------------
    logic                 a_v_reg;
    logic                 b_v_reg;
    logic                 c_v_reg;
    logic [DIV_STEPS:0]   d_v_reg;
    logic [OQ_AW:0]       oq_cnt_reg;

    assign b_en = !d_v_reg[DIV_STEPS] || (oq_cnt_reg != (OQ_AW+1)'(OQ_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= '0;
        end
        else if (b_en)
        begin
            a_v_reg <= mq_pop;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= {d_v_reg[DIV_STEPS-1:0], c_v_reg};
        end
    end

    // ---------------- stage A: queue head ----------------
    ang_pair_t a_pair_reg;

    always_ff @(posedge clk)
    begin
        if (b_en)
            a_pair_reg <= mq_mem[mq_rd_reg];
    end

    // ---------------- stage B: whole degrees, magnitude, deadband ----------------
    logic                  frac_nz;
    logic signed [T_W-1:0] t_fl;
    logic signed [T_W-1:0] t_next;
    ang_t                  db_q;
    ang_t                  m_abs;
    mflag_t                mf_next;
    logic signed [T_W-1:0] t_reg;
    logic [MAG_W-1:0]      mag_reg;
    mflag_t                mf_b_reg;

    assign frac_nz = |a_pair_reg.servo[FRAC_BITS-1:0];
    assign t_fl    = $signed(a_pair_reg.servo[ANG_W-1:FRAC_BITS]);
    // truncate toward zero
    assign t_next  = (a_pair_reg.servo[ANG_W-1] && frac_nz) ? t_fl + T_W'(1) : t_fl;
    assign db_q    = ang_t'({cfg.deadband, {FRAC_BITS{1'b0}}});
    assign m_abs   = a_pair_reg.motor[ANG_W-1] ? -a_pair_reg.motor : a_pair_reg.motor;

    always_comb
    begin
        mf_next.dead    = (a_pair_reg.motor > -db_q) && (a_pair_reg.motor < db_q);
        mf_next.full255 = cfg.max_angle <= {1'b0, cfg.deadband};
        if (mf_next.dead)
            mf_next.dir = DIR_STOP;
        else if (a_pair_reg.motor >= db_q)
            mf_next.dir = DIR_FWD;
        else
            mf_next.dir = DIR_REV;
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            t_reg    <= t_next;
            mag_reg  <= m_abs[MAG_W-1:0];
            mf_b_reg <= mf_next;
        end
    end

    // ---------------- stage C: servo offset, capped tilt minus deadband ----------------
    logic [7:0]       span_e;
    logic [T_W-1:0]   n_next;
    sflag_t           sf_next;
    logic [MAG_W-1:0] mx_q;
    logic [MAG_W-1:0] db_m;
    logic [MAG_W-1:0] capped;
    logic [T_W-1:0]   n_reg;
    sflag_t           sf_c_reg;
    logic [MAG_W-1:0] diff_reg;
    mflag_t           mf_c_reg;

    assign span_e       = (cfg.span == '0) ? 8'd1 : cfg.span;
    assign n_next       = T_W'(span_e) - t_reg;
    assign sf_next.zero = t_reg >= $signed(T_W'(span_e));
    assign sf_next.sat  = n_next >= T_W'({span_e, 1'b0});
    assign mx_q         = MAG_W'({cfg.max_angle, {FRAC_BITS{1'b0}}});
    assign db_m         = MAG_W'({cfg.deadband, {FRAC_BITS{1'b0}}});
    assign capped       = (mag_reg > mx_q) ? mx_q : mag_reg;

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            n_reg    <= n_next;
            sf_c_reg <= sf_next;
            diff_reg <= capped - db_m;
            mf_c_reg <= mf_b_reg;
        end
    end

    // ---------------- stage D: dividends ----------------
    logic [MAG_W+7:0] prod_m;
    logic [7:0]       den_s;
    logic [7:0]       den_m;

    logic [NUM_W-1:0]     rs_w [0:DIV_STEPS];
    logic [NUM_W-1:0]     rm_w [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] qs_w [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] qm_w [0:DIV_STEPS];
    sflag_t               sf_w [0:DIV_STEPS];
    mflag_t               mf_w [0:DIV_STEPS];

    logic [NUM_W-1:0] rs0_reg;
    logic [NUM_W-1:0] rm0_reg;
    sflag_t           sf0_reg;
    mflag_t           mf0_reg;

    // times 255, then drop the Q16 fraction, as the divisor is in whole degrees
    assign prod_m = {diff_reg, 8'b0} - {8'b0, diff_reg};
    assign den_s  = span_e;
    assign den_m  = cfg.max_angle - {1'b0, cfg.deadband};

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            rs0_reg <= NUM_W'(n_reg) * NUM_W'(SERVO_GAIN);
            rm0_reg <= prod_m[FRAC_BITS+NUM_W-1:FRAC_BITS];
            sf0_reg <= sf_c_reg;
            mf0_reg <= mf_c_reg;
        end
    end

    assign rs_w[0] = rs0_reg;
    assign rm_w[0] = rm0_reg;
    assign qs_w[0] = '0;
    assign qm_w[0] = '0;
    assign sf_w[0] = sf0_reg;
    assign mf_w[0] = mf0_reg;

    // ---------------- restoring division, one quotient bit per stage ----------------
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [NUM_W-1:0]     ds;
        logic [NUM_W-1:0]     dm;
        logic                 ge_s;
        logic                 ge_m;
        logic [NUM_W-1:0]     rs_reg;
        logic [NUM_W-1:0]     rm_reg;
        logic [DIV_STEPS-1:0] qs_reg;
        logic [DIV_STEPS-1:0] qm_reg;
        sflag_t               sf_reg;
        mflag_t               mf_reg;

        assign ds   = NUM_W'(den_s) << (DIV_STEPS - 1 - k);
        assign dm   = NUM_W'(den_m) << (DIV_STEPS - 1 - k);
        assign ge_s = rs_w[k] >= ds;
        assign ge_m = rm_w[k] >= dm;

        always_ff @(posedge clk)
        begin
            if (b_en)
            begin
                rs_reg <= ge_s ? rs_w[k] - ds : rs_w[k];
                rm_reg <= ge_m ? rm_w[k] - dm : rm_w[k];
                qs_reg <= {qs_w[k][DIV_STEPS-2:0], ge_s};
                qm_reg <= {qm_w[k][DIV_STEPS-2:0], ge_m};
                sf_reg <= sf_w[k];
                mf_reg <= mf_w[k];
            end
        end

        assign rs_w[k+1] = rs_reg;
        assign rm_w[k+1] = rm_reg;
        assign qs_w[k+1] = qs_reg;
        assign qm_w[k+1] = qm_reg;
        assign sf_w[k+1] = sf_reg;
        assign mf_w[k+1] = mf_reg;
    end

    // ---------------- final select and result queue ----------------
    cmd_t             res;
    cmd_t             oq_mem [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0] oq_wr_reg;
    logic [OQ_AW-1:0] oq_rd_reg;
    logic             oq_push;
    logic             oq_pop;

    always_comb
    begin
        if (sf_w[DIV_STEPS].zero)
            res.servo_position = '0;
        else if (sf_w[DIV_STEPS].sat)
            res.servo_position = SERVO_MAX;
        else
            res.servo_position = qs_w[DIV_STEPS];
        if (mf_w[DIV_STEPS].dead)
            res.motor_speed = '0;
        else if (mf_w[DIV_STEPS].full255)
            res.motor_speed = SPEED_MAX;
        else
            res.motor_speed = qm_w[DIV_STEPS];
        res.motor_direction = mf_w[DIV_STEPS].dir;
    end

    assign oq_push = d_v_reg[DIV_STEPS] && (oq_cnt_reg != (OQ_AW+1)'(OQ_DEPTH));
    assign empty   = oq_cnt_reg == '0;
    assign oq_pop  = pop && !empty;
    assign cmd     = oq_mem[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (oq_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
            case ({oq_push, oq_pop})
                2'b10:   oq_cnt_reg <= oq_cnt_reg + 1'b1;
                2'b01:   oq_cnt_reg <= oq_cnt_reg - 1'b1;
                default: oq_cnt_reg <= oq_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= res;
    end

endmodule

[rtl/tilt_to_drive_command_top.sv]
// Top level of the tilt-to-drive block: configuration registers, front end and back end.
//
// Input side behaves like a queue: drive accel_x/y/z and raise push; the sample
// is taken at a rising edge where push is high and full is low.
// Result side behaves like a queue: while empty is low the oldest command sits on
// servo_position, motor_speed and motor_direction; raise pop to take it.
// Configuration: cfg_valid with cfg_index (0 deadband, 1 max angle, 2 servo span)
// and cfg_data; cfg_ready is always high. Other indexes are ignored. Write only
// while no sample is in flight.
// Throughput: one sample per cycle while full stays low. A sample passes through the
// 16-stage CORDIC pipes and the 8-stage dividers before its command makes empty go low.
// If pop is held low the result queue fills, the back end holds, the angle queue
// fills, then the front end holds and full goes high; nothing is dropped.
// Reset clears every queue and pipeline valid bit and loads deadband 10,
// max angle 30, span 75; the block can take samples as soon as reset is released.
module tilt_to_drive_command_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_x,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_y,
    input  logic signed [ttd_pkg::SAMPLE_WIDTH-1:0] accel_z,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [7:0]                              servo_position,
    output logic [7:0]                              motor_speed,
    output logic [1:0]                              motor_direction,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic [7:0]                              cfg_data
);
    import ttd_pkg::*;

    cfg_t      cfg_reg;
    logic      mid_valid;
    logic      mid_ready;
    ang_pair_t mid_pair;
    cmd_t      cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEADBAND:  cfg_reg.deadband  <= cfg_data[6:0];
                CFG_MAX_ANGLE: cfg_reg.max_angle <= cfg_data;
                CFG_SPAN:      cfg_reg.span      <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ttd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pair  (mid_pair)
    );

    ttd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .in_pair  (mid_pair),
        .empty    (empty),
        .pop      (pop),
        .cmd      (cmd)
    );

    assign servo_position  = cmd.servo_position;
    assign motor_speed     = cmd.motor_speed;
    assign motor_direction = cmd.motor_direction;

endmodule

[rtl/ttd_checker.sv]
// Port-level checker for the tilt-to-drive block and its bind to the top level.
`include "assert_macros.svh"

module ttd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] servo_position,
    input logic [7:0] motor_speed,
    input logic [1:0] motor_direction
);
    import ttd_pkg::*;

    `TTD_ASSERT_IMPLY(a_stop_zero_speed, !empty && motor_direction == DIR_STOP, motor_speed == '0, "stopped command with nonzero speed")
    `TTD_ASSERT_IMPLY(a_servo_range, !empty, servo_position <= SERVO_MAX, "servo position above range")
    `TTD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(servo_position) && $stable(motor_speed) && $stable(motor_direction), "waiting result changed")

endmodule

bind tilt_to_drive_command_top ttd_checker u_ttd_checker (.*);

[verif/tb_tilt_to_drive_command_top.sv]
// Self-checking testbench for the tilt-to-drive block: directed table, then random samples.
`timescale 1ns / 1ps

module tb_tilt_to_drive_command_top;
    import ttd_pkg::*;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  NUM_PHASES = 9;
    localparam int  ITEMS_PER_PHASE = 56;
    localparam longint Q_ONE = 65536;

    // atan(2^-i) in degrees, Q16
    localparam longint ATAN_Q16 [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 fixed;
        logic [7:0]         servo;
        logic [7:0]         speed;
        dir_t               dir;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               empty;
    logic               pop;
    logic [7:0]         servo_position;
    logic [7:0]         motor_speed;
    logic [1:0]         motor_direction;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;

    cmd_t        pending_cmds[$];
    bit          row_fixed;
    cmd_t        row_cmd;
    logic [6:0]  deadband_q;
    logic [7:0]  max_angle_q;
    logic [7:0]  span_q;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          cycle_count;

    tilt_to_drive_command_top i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .accel_x         (accel_x),
        .accel_y         (accel_y),
        .accel_z         (accel_z),
        .empty           (empty),
        .pop             (pop),
        .servo_position  (servo_position),
        .motor_speed     (motor_speed),
        .motor_direction (motor_direction),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // atan2(num, den) in Q16 degrees, vectoring CORDIC
    function automatic longint tilt_q16(longint num, longint den);
        longint cx;
        longint cy;
        longint xs;
        longint ys;
        longint ang;
        longint base;
        ang  = 0;
        base = 0;
        if (num == 0)
            return (den >= 0) ? 0 : 180 * Q_ONE;
        if (den == 0)
            return (num > 0) ? 90 * Q_ONE : -90 * Q_ONE;
        cx = den * Q_ONE;
        cy = num * Q_ONE;
        if (den < 0)
        begin
            cx   = -cx;
            cy   = -cy;
            base = (num > 0) ? 180 * Q_ONE : -180 * Q_ONE;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy > 0)
            begin
                cx  = cx + ys;
                cy  = cy - xs;
                ang = ang + ATAN_Q16[i];
            end
            else if (cy < 0)
            begin
                cx  = cx - ys;
                cy  = cy + xs;
                ang = ang - ATAN_Q16[i];
            end
        end
        return base + ang;
    endfunction

    function automatic cmd_t drive_command(longint ax, longint ay, longint az);
        cmd_t   c;
        longint span;
        longint db;
        longint mx;
        longint t;
        longint pos;
        longint m;
        longint a;
        longint spd;
        span = (span_q == 0) ? 1 : longint'(span_q);
        db   = longint'(deadband_q) * Q_ONE;
        mx   = longint'(max_angle_q) * Q_ONE;
        t    = tilt_q16(ay, az) / Q_ONE;
        pos  = ((t - span) * 180) / (-2 * span);
        if (pos < 0)
            pos = 0;
        if (pos > 180)
            pos = 180;
        m   = tilt_q16(ax, az);
        spd = 0;
        c.motor_direction = DIR_STOP;
        if (!(m > -db && m < db))
        begin
            a = (m < 0) ? -m : m;
            if (mx <= db)
                spd = 255;
            else
            begin
                if (a > mx)
                    a = mx;
                spd = ((a - db) * 255) / (mx - db);
                if (spd < 0)
                    spd = 0;
                if (spd > 255)
                    spd = 255;
            end
            c.motor_direction = (m >= db) ? DIR_FWD : DIR_REV;
        end
        c.servo_position = pos[7:0];
        c.motor_speed    = spd[7:0];
        return c;
    endfunction

    // receiver side
    always @(negedge clk)
        pop = ($urandom_range(99) >= recv_idle_pct);

    // scoreboard: predicts on input transfers, checks on result transfers
    always @(posedge clk)
    begin
        cmd_t exp_cmd;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DEADBAND)
                    deadband_q = cfg_data[6:0];
                else if (cfg_index == CFG_MAX_ANGLE)
                    max_angle_q = cfg_data;
                else if (cfg_index == CFG_SPAN)
                    span_q = cfg_data;
            end
            if (push && !full)
            begin
                exp_cmd = drive_command(accel_x, accel_y, accel_z);
                if (row_fixed)
                    exp_cmd = row_cmd;
                pending_cmds.push_back(exp_cmd);
            end
            if (pop && !empty)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    error_count++;
                end
                else
                begin
                    exp_cmd = pending_cmds.pop_front();
                    if (servo_position !== exp_cmd.servo_position)
                    begin
                        $error("servo_position expected %0d actual %0d",
                               exp_cmd.servo_position, servo_position);
                        error_count++;
                    end
                    if (motor_speed !== exp_cmd.motor_speed)
                    begin
                        $error("motor_speed expected %0d actual %0d",
                               exp_cmd.motor_speed, motor_speed);
                        error_count++;
                    end
                    if (motor_direction !== exp_cmd.motor_direction)
                    begin
                        $error("motor_direction expected %0d actual %0d",
                               exp_cmd.motor_direction, motor_direction);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push    = 1'b1;
        accel_x = x;
        accel_y = y;
        accel_z = z;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        row_fixed = 1'b0;
    endtask

    task automatic drain_results();
        push = 1'b0;
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(5))
            0:       return 16'sd0;
            1:       return 16'(signed'($urandom_range(64)) - 32);
            2:       return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
            3:       return 16'(signed'($urandom_range(4000)) - 2000);
            default: return 16'($urandom());
        endcase
    endfunction

    stim_row_t directed_rows[$];

    initial
    begin
        stim_row_t r;
        logic [7:0] db_val;
        logic [7:0] mx_val;
        logic [7:0] sp_val;
        error_count   = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        accel_x       = '0;
        accel_y       = '0;
        accel_z       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_DEADBAND;
        cfg_data      = '0;
        row_fixed     = 1'b0;
        row_cmd       = '0;
        deadband_q    = 7'd10;
        max_angle_q   = 8'd30;
        span_q        = 8'd75;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // level, flipped, vertical, and the corner values; settings after reset
        directed_rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1, 8'd90, 8'd0, DIR_STOP},
            '{16'sd0, 16'sd0, 16'sd1000, 1, 8'd90, 8'd0, DIR_STOP},
            '{16'sd0, 16'sd0, -16'sd1, 1, 8'd0, 8'd255, DIR_FWD},
            '{16'sd0, 16'sd1, 16'sd0, 1, 8'd0, 8'd0, DIR_STOP},
            '{-16'sd1, -16'sd1, 16'sd0, 1, 8'd180, 8'd255, DIR_REV},
            '{16'sd5, 16'sd0, 16'sd0, 1, 8'd90, 8'd255, DIR_FWD},
            '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, DIR_STOP},
            '{16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, DIR_STOP},
            '{16'sh7FFF, 16'sh8000, 16'sh8000, 0, 0, 0, DIR_STOP},
            '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, DIR_STOP},
            '{16'sh8000, 16'sh8000, 16'sd0, 0, 0, 0, DIR_STOP},
            '{16'sd1, 16'sd1, 16'sh8000, 0, 0, 0, DIR_STOP},
            '{-16'sd1, -16'sd1, 16'sh8000, 0, 0, 0, DIR_STOP},
            '{16'sd176, 16'sd176, 16'sd1000, 0, 0, 0, DIR_STOP},
            '{-16'sd177, 16'sd578, 16'sd1000, 0, 0, 0, DIR_STOP},
            '{16'sd577, -16'sd3732, 16'sd1000, 0, 0, 0, DIR_STOP},
            '{-16'sd600, 16'sd1, 16'sd1000, 0, 0, 0, DIR_STOP},
            '{16'sd1, 16'sd0, -16'sd32767, 0, 0, 0, DIR_STOP}
        };

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            r         = directed_rows[i];
            row_fixed = r.fixed;
            row_cmd   = '{servo_position: r.servo, motor_speed: r.speed,
                          motor_direction: r.dir};
            send_sample(r.x, r.y, r.z);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin db_val = 8'd10;  mx_val = 8'd30;  sp_val = 8'd75;  end
                1: begin db_val = 8'd0;   mx_val = 8'd45;  sp_val = 8'd90;  end
                2: begin db_val = 8'd20;  mx_val = 8'd10;  sp_val = 8'd0;   end
                3: begin db_val = 8'd90;  mx_val = 8'd180; sp_val = 8'd180; end
                4: begin db_val = 8'd0;   mx_val = 8'd1;   sp_val = 8'd1;   end
                5: begin db_val = 8'hFF; mx_val = 8'd255; sp_val = 8'd200; end
                6: begin db_val = 8'd5;   mx_val = 8'd255; sp_val = 8'd255; end
                default:
                begin
                    db_val = 8'($urandom_range(90));
                    mx_val = 8'($urandom_range(180, 1));
                    sp_val = 8'($urandom_range(180, 1));
                end
            endcase
            // unused index must leave every register alone
            write_reg(2'd3, 8'($urandom()));
            write_reg(CFG_DEADBAND, db_val);
            write_reg(CFG_MAX_ANGLE, mx_val);
            write_reg(CFG_SPAN, sp_val);
            write_reg(2'd3, 8'($urandom()));

            if (p < NUM_PHASES / 3)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 52;
            end
            else if (p < 2 * NUM_PHASES / 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 1 && k == ITEMS_PER_PHASE / 2)
                begin
                    push = 1'b0;
                    while (pending_cmds.size() != 0)
                        @(negedge clk);
                end
                send_sample(rand_axis(), rand_axis(), rand_axis());
            end
            drain_results();
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ttd_pkg.sv
rtl/ttd_cordic.sv
rtl/ttd_front.sv
rtl/ttd_back.sv
rtl/tilt_to_drive_command_top.sv
rtl/ttd_checker.sv
verif/tb_tilt_to_drive_command_top.sv
